// ===== rtl/bfr_pkg.sv =====
// Shared types and constants of the byte frame receiver with XOR check.
// Holds the request and result structs, field codes and configuration defaults.
// Depends on nothing; bfr_cfg and the core take from it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

	// Default buffer size; the payload store holds four bytes fewer.
	localparam int BUFFER_BYTES_DEF = 64;
	localparam int FRAME_OVERHEAD   = 4;

	// Start-of-frame marker.
	localparam logic [7:0] SOF_MARK = 8'hAA;

	// Input operation codes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
	localparam logic [1:0] STATUS_LENGTH   = 2'd2;
	localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

	// Configuration port.
	localparam int          ADDR_W          = 3;
	localparam int          DATA_W          = 32;
	localparam logic        REG_TIMEOUT     = 1'b0;
	localparam logic [15:0] TIMEOUT_DEFAULT = 16'd100;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] msg_type;
		logic [5:0] payload_len;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       last;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/bfr_store.sv =====
// Payload store: single-port-write, single-port-read synchronous RAM.
// Read data is registered: it appears in the cycle after the read enable.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module bfr_store #(
	parameter int DEPTH = 60,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bfr_cfg.sv =====
// APB-style configuration register block: holds the timeout limit.
// Depends on bfr_pkg for address width, register index and reset value.
`timescale 1ns / 1ps
`default_nettype none

module bfr_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bfr_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bfr_pkg::DATA_W-1:0]   pwdata,
	output logic      [bfr_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output logic      [15:0]                  timeout_ticks
);

	logic reg_sel;
	logic [15:0] timeout_q;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[bfr_pkg::ADDR_W-1] == bfr_pkg::REG_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= bfr_pkg::TIMEOUT_DEFAULT;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// Unmapped addresses read as zero.
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(bfr_pkg::DATA_W-16){1'b0}}, timeout_q};
		end
	end

	assign timeout_ticks = timeout_q;

endmodule

`default_nettype wire

// ===== rtl/byte_frame_receiver_xor_check_core.sv =====
// Byte frame receiver with XOR check: start byte, type, length, payload, checksum.
// A status-only result (error or empty frame) is registered in the cycle after the
// request that causes it; a payload run follows the checksum request, each byte a
// store read (CTL_READ), then an output load (CTL_WAIT) that waits for room.
// Throughput: 1 request per cycle with no run and no stalled result; else input stalls.
// Reset clears framing state and sets timeout to 100; the payload store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module byte_frame_receiver_xor_check_core #(
	parameter int BUFFER_BYTES = bfr_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire bfr_pkg::in_item_t          in_data,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output bfr_pkg::out_item_t              out_data,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bfr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bfr_pkg::DATA_W-1:0] pwdata,
	output logic      [bfr_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);

	// Store depth, address width and byte-count width all follow the buffer size.
	localparam int STORE_DEPTH = BUFFER_BYTES - bfr_pkg::FRAME_OVERHEAD;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);

	// Framing phase of the byte stream.
	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_TYPE    = 5'b00010,
		PH_LEN     = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	// Request handling: take input, or walk the store emitting a payload run.
	typedef enum logic [2:0] {
		CTL_RUN  = 3'b001,
		CTL_READ = 3'b010,
		CTL_WAIT = 3'b100
	} ctl_t;

	phase_t phase_q, phase_d;
	ctl_t   ctl_q, ctl_d;

	logic [7:0]    type_q, type_d;
	logic [7:0]    len_q, len_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
	logic [CW-1:0] rd_q, rd_d, rd_inc;
	logic [7:0]    xor_q, xor_d;
	logic [15:0]   ticks_q, ticks_d, ticks_inc;

	logic               out_valid_q;
	bfr_pkg::out_item_t out_data_q, res;
	logic               res_load;

	logic        in_take, out_free;
	logic [7:0]  b;
	logic [15:0] timeout_ticks;

	logic       wr_en, rd_en;
	logic [7:0] rd_data;

	bfr_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	bfr_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (b),
		.rd_en   (rd_en),
		.rd_addr (rd_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// The output register frees when empty or taken this cycle. Hold input
	// off during a payload run and while a result waits stalled.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (ctl_q != CTL_RUN) || (out_valid_q && out_stall);
	assign in_take  = in_valid && !in_stall;
	assign b        = in_data.rx_byte;

	assign cnt_inc   = cnt_q + CW'(1);
	assign rd_inc    = rd_q + CW'(1);
	assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		ctl_d    = ctl_q;
		type_d   = type_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		rd_d     = rd_q;
		xor_d    = xor_q;
		ticks_d  = ticks_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		res_load = 1'b0;
		res.status      = bfr_pkg::STATUS_OK;
		res.data_byte   = 8'd0;
		res.data_valid  = 1'b0;
		res.last        = 1'b1;

		unique case (ctl_q)
			CTL_RUN: begin
				if (in_take) begin
					if (in_data.opcode == bfr_pkg::OP_TICK) begin
						// Ticks count only once the length is known.
						if (phase_q == PH_PAYLOAD || phase_q == PH_CHECK) begin
							ticks_d = ticks_inc;
							if (ticks_inc > timeout_ticks) begin
								res_load   = 1'b1;
								res.status = bfr_pkg::STATUS_TIMEOUT;
								phase_d    = PH_HUNT;
							end
						end
					end else begin
						unique case (phase_q)
							PH_HUNT: begin
								if (b == bfr_pkg::SOF_MARK) begin
									xor_d   = bfr_pkg::SOF_MARK;
									phase_d = PH_TYPE;
								end
							end
							PH_TYPE: begin
								type_d  = b;
								xor_d   = xor_q ^ b;
								phase_d = PH_LEN;
							end
							PH_LEN: begin
								len_d = b;
								xor_d = xor_q ^ b;
								if (b > 8'(STORE_DEPTH)) begin
									res_load   = 1'b1;
									res.status = bfr_pkg::STATUS_LENGTH;
									phase_d    = PH_HUNT;
								end else begin
									ticks_d = 16'd0;
									cnt_d   = '0;
									phase_d = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
								end
							end
							PH_PAYLOAD: begin
								wr_en = (cnt_q < CW'(STORE_DEPTH));
								xor_d = xor_q ^ b;
								cnt_d = cnt_inc;
								if (8'(cnt_inc) >= len_q) begin
									phase_d = PH_CHECK;
								end
							end
							PH_CHECK: begin
								phase_d = PH_HUNT;
								if (b != xor_q) begin
									res_load   = 1'b1;
									res.status = bfr_pkg::STATUS_CHECKSUM;
								end else if (len_q == 8'd0) begin
									res_load = 1'b1;
								end else begin
									// Good frame with payload: start the store walk.
									rd_d  = '0;
									ctl_d = CTL_READ;
								end
							end
							default: begin
								phase_d = PH_HUNT;
							end
						endcase
					end
				end
			end
			CTL_READ: begin
				rd_en = 1'b1;
				ctl_d = CTL_WAIT;
			end
			CTL_WAIT: begin
				// Read data holds until the next read, so wait here for room.
				if (out_free) begin
					res_load       = 1'b1;
					res.data_byte  = rd_data;
					res.data_valid = 1'b1;
					res.last       = (8'(rd_inc) == len_q);
					if (8'(rd_inc) == len_q) begin
						ctl_d = CTL_RUN;
					end else begin
						rd_d  = rd_inc;
						ctl_d = CTL_READ;
					end
				end
			end
			default: begin
				ctl_d = CTL_RUN;
			end
		endcase

		// A length error reports the new length byte's low six bits; on other results len_d equals len_q.
		res.msg_type    = type_q;
		res.payload_len = len_d[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			ctl_q       <= CTL_RUN;
			type_q      <= 8'd0;
			len_q       <= 8'd0;
			cnt_q       <= '0;
			rd_q        <= '0;
			xor_q       <= 8'd0;
			ticks_q     <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			ctl_q   <= ctl_d;
			type_q  <= type_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			rd_q    <= rd_d;
			xor_q   <= xor_d;
			ticks_q <= ticks_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load a fresh result only when the register frees; otherwise hold it.
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
